[design/rain_gauge_window_rate_assert.svh]
// assertion macros for the rain gauge window rate block
// no dependencies; included by the top level only
`ifndef RAIN_GAUGE_WINDOW_RATE_ASSERT_SVH
`define RAIN_GAUGE_WINDOW_RATE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define RGWR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rgwr assertion failed");

// next-cycle implication, disabled while reset is low
`define RGWR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rgwr assertion failed");

`endif

[design/rgwr_pkg.sv]
// shared types and constants for the rain gauge window rate block
// no dependencies
package rgwr_pkg;

    localparam int unsigned NOW_W      = 32;
    localparam int unsigned WINDOW_W   = 27;
    localparam int unsigned DEBOUNCE_W = 10;
    localparam int unsigned STEP_W     = 16;
    localparam int unsigned TIPCNT_W   = 7;
    localparam int unsigned RATE_W     = 22;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 27;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;

    // register reset values
    localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 27'd3600000;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd10;
    localparam logic [STEP_W-1:0]     STEP_RST     = 16'd279;

    // item kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_TIP  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [NOW_W-1:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [TIPCNT_W-1:0] tip_count;
        logic [RATE_W-1:0]   rain_rate;
        logic [NOW_W-1:0]    last_tip_ms;
        logic                tip_accepted;
        logic                tip_dropped;
    } out_item_t;

endpackage

[design/rain_gauge_window_rate.sv]
// rain gauge with debounced tip ring and sliding-window rain rate
// depends on rgwr_pkg, rgwr_ram and rain_gauge_window_rate_assert.svh
//
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    in_item_t  {kind, now_ms}
// m_        out  m_valid/m_ready    out_item_t {tip_count, rain_rate, last_tip_ms, flags}
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// a tip item passes from accept to result through the check, multiply and output steps
// a tick item compares stored times one at a time: each tip that has expired,
// plus the first tip kept when the ring does not empty
// each compare waits on the registered read of the timestamp ram, which sets the pace
// one subtract-and-compare unit serves both the debounce and the expiry check
// aresetn is synchronous; it empties the ring and loads register defaults
// a result held on m_ stalls only the final load; the next item is taken while it waits, but not while a load stalls
`include "rain_gauge_window_rate_assert.svh"

module rain_gauge_window_rate
    import rgwr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
    localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int unsigned PROD_W = CNT_W + STEP_W;
    localparam int unsigned EXT_W  = (PROD_W > RATE_W) ? PROD_W : RATE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_WAIT,
        S_TICK_CMP,
        S_TIP,
        S_MUL,
        S_OUT
    } state_t;

    // sequencer and ring state
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NOW_W-1:0]     last_reg, last_next;

    // current item
    logic [NOW_W-1:0]     now_reg, now_next;
    logic                 acc_reg, acc_next;
    logic                 drop_reg, drop_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    // config registers
    logic [WINDOW_W-1:0]   window_reg, window_next;
    logic [DEBOUNCE_W-1:0] debounce_reg, debounce_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_data_reg, m_data_next;

    // ram
    logic                 ram_we;
    logic [NOW_W-1:0]     ram_rdata;

    // shared subtract and compare unit
    logic [NOW_W-1:0]     cmp_ref;
    logic [NOW_W-1:0]     cmp_limit;
    logic [NOW_W-1:0]     cmp_age;
    logic                 cmp_gt;

    logic                 full;
    logic                 tip_pass;
    logic [EXT_W-1:0]     prod_ext;
    logic [RATE_W-1:0]    rate_sat;

    rgwr_ram #(
        .WIDTH (NOW_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (now_reg),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // expiry compares the oldest stored time against the window,
    // debounce compares the newest time against the debounce gap
    always_comb begin
        if (state_reg == S_TICK_CMP) begin
            cmp_ref   = ram_rdata;
            cmp_limit = NOW_W'(window_reg);
        end else begin
            cmp_ref   = last_reg;
            cmp_limit = NOW_W'(debounce_reg);
        end
        cmp_age = now_reg - cmp_ref;
        cmp_gt  = cmp_age > cmp_limit;
    end

    assign full     = count_reg >= CNT_W'(RING_DEPTH);
    assign tip_pass = (count_reg == '0) || cmp_gt;
    assign ram_we   = (state_reg == S_TIP) && tip_pass && !full;

    // rate saturation for deep rings
    assign prod_ext = EXT_W'(prod_reg);
    assign rate_sat = (prod_ext > EXT_W'(RATE_MAX)) ? RATE_MAX : prod_ext[RATE_W-1:0];

    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        now_next      = now_reg;
        acc_next      = acc_reg;
        drop_next     = drop_reg;
        prod_next     = prod_reg;
        window_next   = window_reg;
        debounce_next = debounce_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // config writes, unknown index ignored
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WINDOW:   window_next   = cfg_wdata[WINDOW_W-1:0];
                REG_DEBOUNCE: debounce_next = cfg_wdata[DEBOUNCE_W-1:0];
                REG_STEP:     step_next     = cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    now_next  = s_data.now_ms;
                    acc_next  = 1'b0;
                    drop_next = 1'b0;
                    if (s_data.kind == KIND_TIP) begin
                        state_next = S_TIP;
                    end else if (count_reg != '0) begin
                        state_next = S_TICK_WAIT;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_TICK_WAIT: begin
                // ram read of the oldest entry lands this edge
                state_next = S_TICK_CMP;
            end
            S_TICK_CMP: begin
                if (cmp_gt) begin
                    rd_idx_next = (rd_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                         : rd_idx_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    state_next  = (count_reg == CNT_W'(1)) ? S_MUL : S_TICK_WAIT;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_TIP: begin
                if (tip_pass) begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        wr_idx_next = (wr_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                             : wr_idx_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                        last_next   = now_reg;
                        acc_next    = 1'b1;
                    end
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = PROD_W'(count_reg) * PROD_W'(step_reg);
                state_next = S_OUT;
            end
            S_OUT: begin
                // load only once the previous result has left
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.tip_count    = TIPCNT_W'(count_reg);
                    m_data_next.rain_rate    = rate_sat;
                    m_data_next.last_tip_ms  = (count_reg == '0) ? '0 : last_reg;
                    m_data_next.tip_accepted = acc_reg;
                    m_data_next.tip_dropped  = drop_reg;
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            count_reg    <= '0;
            window_reg   <= WINDOW_RST;
            debounce_reg <= DEBOUNCE_RST;
            step_reg     <= STEP_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            count_reg    <= count_next;
            window_reg   <= window_next;
            debounce_reg <= debounce_next;
            step_reg     <= step_next;
            m_valid_reg  <= m_valid_next;
        end
        // payload, no reset needed
        last_reg   <= last_next;
        now_reg    <= now_next;
        acc_reg    <= acc_next;
        drop_reg   <= drop_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ring never holds more than its depth
    `RGWR_ASSERT_NOW(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_W'(RING_DEPTH))
    // a result never carries both flags
    `RGWR_ASSERT_NOW(a_flags_excl, aclk, aresetn, m_valid_reg, !(m_data_reg.tip_accepted && m_data_reg.tip_dropped))
    // a new result only appears after the output step
    `RGWR_ASSERT_NOW(a_rise_from_out, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == S_OUT))
    // a tick never grows the ring
    `RGWR_ASSERT_NEXT(a_tick_no_grow, aclk, aresetn, state_reg == S_TICK_CMP, count_reg <= $past(count_reg))

endmodule

[design/rgwr_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rgwr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
